// ----- rtl/core/tcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types, codes and text tables of the command line recognizer.
// ----------------------------------------------------------------------------
package tcl_pkg;

	localparam int TCL_LINE_CAP = 64;

	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic [2:0] KIND_LED_ON  = 3'd0;
	localparam logic [2:0] KIND_LED_OFF = 3'd1;
	localparam logic [2:0] KIND_STATUS  = 3'd2;
	localparam logic [2:0] KIND_I2C     = 3'd3;
	localparam logic [2:0] KIND_SPI     = 3'd4;
	localparam logic [2:0] KIND_QSPI    = 3'd5;
	localparam logic [2:0] KIND_UNKNOWN = 3'd6;

	localparam int TXT_COUNT = 6;
	localparam int TXT_MAX   = 10;

	typedef struct packed {
		logic wr_char;
		logic bksp;
		logic ovf;
		logic line_clr;
		logic scan_clr;
		logic rd_issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic byte_bs;
		logic byte_cr;
		logic byte_lf;
		logic cnt_zero;
		logic cnt_full;
		logic rd_done;
		logic rd_pend;
	} sts_t;

	function automatic int txt_len(input logic [2:0] k);
		int n;
		n = 0;
		unique case (k)
			KIND_LED_ON:  n = 6;
			KIND_LED_OFF: n = 7;
			KIND_STATUS:  n = 6;
			KIND_I2C:     n = 9;
			KIND_SPI:     n = 9;
			KIND_QSPI:    n = 10;
			default:      n = 0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] txt_char(input logic [2:0] k, input logic [3:0] i);
		logic [8*TXT_MAX-1:0] s;
		s = '0;
		unique case (k)
			KIND_LED_ON:  s = "LED ON    ";
			KIND_LED_OFF: s = "LED OFF   ";
			KIND_STATUS:  s = "STATUS    ";
			KIND_I2C:     s = "I2C MODE  ";
			KIND_SPI:     s = "SPI MODE  ";
			KIND_QSPI:    s = "QSPI MODE ";
			default:      s = '0;
		endcase
		if (int'(i) >= TXT_MAX) begin
			return 8'h00;
		end
		return s[(TXT_MAX - 1 - int'(i)) * 8 +: 8];
	endfunction

endpackage

// ----- rtl/core/tcl_ram.sv -----
// ----------------------------------------------------------------------------
// tcl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/tcl_num_parse.sv -----
// ----------------------------------------------------------------------------
// tcl_num_parse
// Character-serial signed decimal parser with 32-bit saturation.
// ----------------------------------------------------------------------------
module tcl_num_parse #(
	parameter int START = 9,
	parameter int W     = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clr,
	input  logic         en,
	input  logic [W-1:0] pos,
	input  logic [7:0]   c,
	input  logic [W-1:0] len,
	output logic [31:0]  val,
	output logic         ok
);

	localparam logic [1:0] PH_BLANK = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_END   = 2'd3;

	logic [1:0]  phase_q;
	logic        neg_q;
	logic        any_q;
	logic [31:0] mag_q;

	logic        active;
	logic        is_dig;
	logic        is_blank;
	logic        is_sign;
	logic [3:0]  dig;
	logic [35:0] mag36;
	logic [35:0] nxt36;
	logic [31:0] lim;
	logic [31:0] mag_nxt;

	always_comb begin
		active   = en && (int'(pos) >= START);
		is_dig   = (c >= "0") && (c <= "9");
		is_blank = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
		is_sign  = (c == "+") || (c == "-");
		dig      = 4'(c - "0");
		mag36    = {4'b0, mag_q};
		nxt36    = (mag36 << 3) + (mag36 << 1) + {32'b0, dig};
		lim      = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		mag_nxt  = (nxt36 > {4'b0, lim}) ? lim : nxt36[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			any_q   <= 1'b0;
			mag_q   <= '0;
		end else if (clr) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			any_q   <= 1'b0;
			mag_q   <= '0;
		end else if (active) begin
			unique case (phase_q)
				PH_BLANK: begin
					if (is_blank) begin
						phase_q <= PH_BLANK;
					end else if (is_sign) begin
						neg_q   <= (c == "-");
						phase_q <= PH_SIGN;
					end else if (is_dig) begin
						any_q   <= 1'b1;
						mag_q   <= mag_nxt;
						phase_q <= PH_DIGIT;
					end else begin
						phase_q <= PH_END;
					end
				end
				PH_SIGN, PH_DIGIT: begin
					if (is_dig) begin
						any_q   <= 1'b1;
						mag_q   <= mag_nxt;
						phase_q <= PH_DIGIT;
					end else begin
						phase_q <= PH_END;
					end
				end
				default: phase_q <= PH_END;
			endcase
		end
	end

	always_comb begin
		if (!any_q) begin
			val = '0;
			ok  = (int'(len) <= START);
		end else begin
			val = neg_q ? 32'(32'd0 - mag_q) : mag_q;
			ok  = (phase_q != PH_END);
		end
	end

endmodule

// ----- rtl/core/tcl_datapath.sv -----
// ----------------------------------------------------------------------------
// tcl_datapath
// Line store, character count, scan matcher, number parsers and result
// register of the command line recognizer.
// ----------------------------------------------------------------------------
module tcl_datapath #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcl_pkg::cmd_t     cmd,
	input  logic [7:0]        rx_byte,
	output tcl_pkg::sts_t     sts,
	output logic [2:0]        command_kind,
	output logic signed [31:0] mode_value,
	output logic              mode_accepted
);

	import tcl_pkg::*;

	localparam int CW = $clog2(LINE_CAPACITY);
	localparam logic [CW-1:0] CNT_MAX = CW'(LINE_CAPACITY - 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] addr_q;
	logic [CW-1:0] len_q;
	logic          dv_s1;
	logic          stop_q;
	logic [TXT_COUNT-1:0] match_q;
	logic [TXT_COUNT-1:0] match_nxt;
	logic [7:0]    rdata;
	logic          proc;
	logic [31:0]   val9;
	logic          ok9;
	logic [31:0]   val10;
	logic          ok10;

	logic [2:0]    kind_c;
	logic [31:0]   val_c;
	logic          ok_c;

	logic [2:0]    kind_q;
	logic [31:0]   val_q;
	logic          ok_q;

	tcl_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_char),
		.waddr(count_q),
		.wdata(rx_byte),
		.re   (cmd.rd_issue),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign proc = dv_s1 && !stop_q && (rdata != 8'h00);

	tcl_num_parse #(.START(9), .W(CW)) u_parse9 (
		.clk(clk), .arst_n(arst_n), .clr(cmd.scan_clr), .en(proc),
		.pos(len_q), .c(rdata), .len(len_q), .val(val9), .ok(ok9)
	);

	tcl_num_parse #(.START(10), .W(CW)) u_parse10 (
		.clk(clk), .arst_n(arst_n), .clr(cmd.scan_clr), .en(proc),
		.pos(len_q), .c(rdata), .len(len_q), .val(val10), .ok(ok10)
	);

	always_comb begin
		sts.byte_bs  = (rx_byte == CH_BS);
		sts.byte_cr  = (rx_byte == CH_CR);
		sts.byte_lf  = (rx_byte == CH_LF);
		sts.cnt_zero = (count_q == '0);
		sts.cnt_full = (count_q == CNT_MAX);
		sts.rd_done  = (addr_q == count_q);
		sts.rd_pend  = dv_s1;
	end

	always_comb begin
		match_nxt = match_q;
		for (int k = 0; k < TXT_COUNT; k++) begin
			if ((int'(len_q) < txt_len(3'(k))) && (rdata != txt_char(3'(k), len_q[3:0]))) begin
				match_nxt[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			addr_q  <= '0;
			len_q   <= '0;
			dv_s1   <= 1'b0;
			stop_q  <= 1'b0;
			match_q <= '1;
		end else begin
			dv_s1 <= cmd.rd_issue;
			if (cmd.wr_char) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.bksp) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.ovf || cmd.line_clr) begin
				count_q <= '0;
			end
			if (cmd.scan_clr) begin
				addr_q  <= '0;
				len_q   <= '0;
				stop_q  <= 1'b0;
				match_q <= '1;
			end else begin
				if (cmd.rd_issue) begin
					addr_q <= addr_q + 1'b1;
				end
				if (dv_s1 && !stop_q) begin
					if (rdata == 8'h00) begin
						stop_q <= 1'b1;
					end else begin
						len_q   <= len_q + 1'b1;
						match_q <= match_nxt;
					end
				end
			end
		end
	end

	// first matching class wins
	always_comb begin
		kind_c = KIND_UNKNOWN;
		val_c  = '0;
		ok_c   = 1'b0;
		priority if (match_q[KIND_LED_ON] && (int'(len_q) == txt_len(KIND_LED_ON))) begin
			kind_c = KIND_LED_ON;
		end else if (match_q[KIND_LED_OFF] && (int'(len_q) == txt_len(KIND_LED_OFF))) begin
			kind_c = KIND_LED_OFF;
		end else if (match_q[KIND_STATUS] && (int'(len_q) == txt_len(KIND_STATUS))) begin
			kind_c = KIND_STATUS;
		end else if (match_q[KIND_I2C] && (int'(len_q) >= txt_len(KIND_I2C))) begin
			kind_c = KIND_I2C;
			val_c  = val9;
			ok_c   = ok9;
		end else if (match_q[KIND_SPI] && (int'(len_q) >= txt_len(KIND_SPI))) begin
			kind_c = KIND_SPI;
			val_c  = val9;
			ok_c   = ok9;
		end else if (match_q[KIND_QSPI] && (int'(len_q) >= txt_len(KIND_QSPI))) begin
			kind_c = KIND_QSPI;
			val_c  = val10;
			ok_c   = ok10;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind_q <= kind_c;
			val_q  <= val_c;
			ok_q   <= ok_c;
		end
	end

	assign command_kind  = kind_q;
	assign mode_value    = signed'(val_q);
	assign mode_accepted = ok_q;

endmodule

// ----- rtl/core/tcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcl_ctrl
// Controller of the command line recognizer: byte handling, line scan
// sequencing and result handshake.
// ----------------------------------------------------------------------------
module tcl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  tcl_pkg::sts_t sts,
	output tcl_pkg::cmd_t cmd
);

	import tcl_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       in_take;
	logic       out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					priority if (sts.byte_bs) begin
						cmd.bksp = !sts.cnt_zero;
					end else if (sts.byte_cr) begin
						cmd = '0;
					end else if (sts.byte_lf) begin
						if (!sts.cnt_zero) begin
							cmd.scan_clr = 1'b1;
							state_nxt    = ST_SCAN;
						end
					end else if (sts.cnt_full) begin
						cmd.ovf = 1'b1;
					end else begin
						cmd.wr_char = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd_issue = !sts.rd_done;
				if (sts.rd_done && !sts.rd_pend) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.line_clr = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an unaccepted result");

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> !sts.rd_done)
		else $error("line read past the stored count");

	a_lf_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && sts.byte_lf && !sts.cnt_zero) |=> (state_q == ST_SCAN))
		else $error("line feed on a non-empty line did not start a scan");

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !sts.rd_pend)
		else $error("result stage entered with a read in flight");
`endif

endmodule

// ----- rtl/core/text_command_line_recognizer.sv -----
// ----------------------------------------------------------------------------
// text_command_line_recognizer
// Collects received bytes into a line and classifies each completed line
// as a command, parsing the decimal value of the mode commands.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_stall  | rx_byte
//  output   | out_valid / out_stall| command_kind, mode_value, mode_accepted
//
//  an ordinary byte, backspace or carriage return is handled as it is accepted
//  a line feed on a non-empty line is accepted, the line is read back
//  through the registered store port up to the stored count, and the result
//  is loaded once the output register is free and stays valid until taken
//  in_stall is high during the scan and while a result waits for the
//  output register; the line store needs no clearing pass after reset
// ----------------------------------------------------------------------------
module text_command_line_recognizer #(
	parameter int LINE_CAPACITY = tcl_pkg::TCL_LINE_CAP
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         command_kind,
	output logic signed [31:0] mode_value,
	output logic               mode_accepted
);

	import tcl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcl_datapath #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rx_byte      (rx_byte),
		.sts          (sts),
		.command_kind (command_kind),
		.mode_value   (mode_value),
		.mode_accepted(mode_accepted)
	);

endmodule
